FILE: design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition post must hold in the same cycle as pre.
`define CHK_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// The condition post must hold in the cycle after pre.
`define CHK_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: design/shmc_pkg.sv
`default_nettype none

package shmc_pkg;

	// Field and state widths.
	localparam int ANGLE_W   = 16;
	localparam int SPR_W     = 13;
	localparam int IVL_W     = 16;
	localparam int STEP_W    = 19;
	localparam int PHASE_W   = 3;
	localparam int COIL_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;
	localparam int OUT_W     = 8;

	// Product of steps per revolution and angle magnitude fits in 28 bits.
	localparam int PROD_W = SPR_W + ANGLE_W - 1;
	// Quotient by 360 fits in 20 bits before saturation.
	localparam int QUOT_W = 20;

	// Division by 360 as multiplication by a rounded-up reciprocal.
	localparam int RECIP_SHIFT = 37;
	localparam int RECIP_W     = 29;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd359) / 64'd360);
	localparam int MUL_W = PROD_W + RECIP_W;

	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
	localparam logic [IVL_W-1:0]  ELAPSED_MAX = {IVL_W{1'b1}};

	localparam logic [SPR_W-1:0] SPR_RESET = SPR_W'(2048);
	localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(2);

	// Item kinds carried on tuser.
	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_MOVE = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEPS_PER_REV = 1'b0,
		REG_STEP_INTERVAL = 1'b1
	} reg_idx_t;

	// Load enables for the conversion pipeline.
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	// Half-step coil pattern.
	function automatic logic [COIL_W-1:0] half_step_coils(input logic [PHASE_W-1:0] idx);
		logic [COIL_W-1:0] c;
		case (idx)
			3'd0: c = 4'h1;
			3'd1: c = 4'h3;
			3'd2: c = 4'h2;
			3'd3: c = 4'h6;
			3'd4: c = 4'h4;
			3'd5: c = 4'hC;
			3'd6: c = 4'h8;
			default: c = 4'h9;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/shmc_angle_conv.sv
`default_nettype none

// Converts an angle into a step magnitude over two registered stages:
// a multiply by steps per revolution, then a reciprocal multiply by 1/360.
module shmc_angle_conv (
	input  wire logic                          clk,
	input  wire shmc_pkg::stage_en_t           en,
	input  wire logic [shmc_pkg::SPR_W-1:0]    steps_per_rev,
	input  wire logic [shmc_pkg::ANGLE_W-1:0]  angle_s1,
	output logic      [shmc_pkg::QUOT_W-1:0]   quot_s3,
	output logic                               neg_s3
);
	import shmc_pkg::*;

	logic [ANGLE_W-1:0] angle_mag;
	logic [PROD_W-1:0]  prod_s2;
	logic               neg_s2;
	logic [MUL_W-1:0]   recip_prod;

	// Magnitude of the signed angle; the most negative value maps to 2^15.
	assign angle_mag = angle_s1[ANGLE_W-1] ? ANGLE_W'(-angle_s1) : angle_s1;

	// First stage: steps per revolution times angle magnitude.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PROD_W'(steps_per_rev) * PROD_W'(angle_mag);
			neg_s2  <= angle_s1[ANGLE_W-1];
		end
	end

	// The rounded-up reciprocal gives the exact floor for every product in range.
	assign recip_prod = MUL_W'(prod_s2) * MUL_W'(RECIP);

	// Second stage: quotient by 360, truncated toward zero on the magnitude.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			quot_s3 <= recip_prod[RECIP_SHIFT +: QUOT_W];
			neg_s3  <= neg_s2;
		end
	end

endmodule

`default_nettype wire

FILE: design/stepper_half_step_move_controller.sv
// Half-step sequencer for a four-phase unipolar stepper motor.
//
// Input channel s_*: each word is either a tick (tuser = 0) or a move
// (tuser = 1) whose tdata holds a signed angle in degrees. A move sets a
// step target of steps_per_rev * angle / 360 and a direction; each tick
// may take one half step once step_interval ticks have passed.
// Output channel m_*: exactly one result word per input word, in order,
// holding the coil drive, a stepped flag and a busy flag.
// Path: an accepted input word passes through the input register, the
// product stage and the quotient stage, then the state update into the
// output register. Throughput is one word per cycle while the receiver
// keeps m_tready high; the two multiplier stages are registered.
// When the receiver stalls, the output register holds its word and the
// pipeline keeps filling its empty stages before tready drops.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (0 = steps_per_rev, 1 = step_interval). Write only while the block is idle.
// Reset (arst_n low) clears all motion state, turns the coils off, empties
// the pipeline and loads steps_per_rev = 2048 and step_interval = 2.
`default_nettype none
`include "assert_macros.svh"

module stepper_half_step_move_controller (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input word.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [shmc_pkg::ANGLE_W-1:0]      s_tdata,   // [15:0] angle
	input  wire logic                              s_tuser,   // [0] cmd
	// Result word.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [shmc_pkg::OUT_W-1:0]        m_tdata,   // [3:0] coils, [4] stepped,
	                                                          // [5] busy_res, [7:6] zero
	// Configuration writes.
	input  wire logic                              cfg_we,
	input  wire logic [shmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [shmc_pkg::CFG_W-1:0]        cfg_wdata
);
	import shmc_pkg::*;

	// Configuration registers.
	logic [SPR_W-1:0] steps_per_rev_q;
	logic [IVL_W-1:0] step_interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_per_rev_q <= SPR_RESET;
			step_interval_q <= IVL_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STEPS_PER_REV: steps_per_rev_q <= cfg_wdata[SPR_W-1:0];
				REG_STEP_INTERVAL: step_interval_q <= cfg_wdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline occupancy and the item kind that travels with each stage.
	logic               v_s1, v_s2, v_s3;
	cmd_t               cmd_s1, cmd_s2, cmd_s3;
	logic [ANGLE_W-1:0] angle_s1;
	logic               out_valid_q;
	logic               en_s1, en_out;
	stage_en_t          en;

	// A stage loads when it is empty or its word moves on.
	assign en_out = !out_valid_q || m_tready;
	assign en.s3  = !v_s3 || en_out;
	assign en.s2  = !v_s2 || en.s3;
	assign en_s1  = !v_s1 || en.s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1   <= cmd_t'(s_tuser);
			angle_s1 <= s_tdata;
		end
		if (en.s2) cmd_s2 <= cmd_s1;
		if (en.s3) cmd_s3 <= cmd_s2;
	end

	// Angle to step count conversion.
	logic [QUOT_W-1:0] quot_s3;
	logic              neg_s3;

	shmc_angle_conv u_conv (
		.clk           (clk),
		.en            (en),
		.steps_per_rev (steps_per_rev_q),
		.angle_s1      (angle_s1),
		.quot_s3       (quot_s3),
		.neg_s3        (neg_s3)
	);

	// Motion state.
	logic [STEP_W-1:0]  target_q, done_q;
	logic               dir_up_q;
	logic [PHASE_W-1:0] phase_q;
	logic [IVL_W-1:0]   elapsed_q;
	logic [COIL_W-1:0]  coil_q;

	logic [STEP_W-1:0]  target_d, done_d, target_sat;
	logic               dir_up_d;
	logic [PHASE_W-1:0] phase_d;
	logic [IVL_W-1:0]   elapsed_d, elapsed_inc;
	logic [COIL_W-1:0]  coil_d;
	logic               stepped_d;
	logic               upd;

	assign upd = v_s3 && en_out;
	assign target_sat = (quot_s3 > QUOT_W'(STEP_MAX)) ? STEP_MAX : quot_s3[STEP_W-1:0];
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	// Next state for the word leaving the last stage.
	always_comb begin
		target_d  = target_q;
		done_d    = done_q;
		dir_up_d  = dir_up_q;
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		coil_d    = coil_q;
		stepped_d = 1'b0;
		if (cmd_s3 == CMD_MOVE) begin
			// A move that comes to zero steps keeps the old target and direction.
			if (quot_s3 != '0) begin
				target_d = target_sat;
				dir_up_d = !neg_s3;
			end
			done_d = '0;
		end else begin
			elapsed_d = elapsed_inc;
			if (done_q < target_q) begin
				if (elapsed_inc >= step_interval_q) begin
					coil_d    = half_step_coils(phase_q);
					phase_d   = dir_up_q ? phase_q + 1'b1 : phase_q - 1'b1;
					done_d    = done_q + 1'b1;
					elapsed_d = '0;
					stepped_d = 1'b1;
				end
			end else if (target_q != '0 && done_q == target_q) begin
				// First tick after the last step releases the coils.
				coil_d   = '0;
				target_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			done_q    <= '0;
			dir_up_q  <= 1'b0;
			phase_q   <= '0;
			elapsed_q <= '0;
			coil_q    <= '0;
		end else if (upd) begin
			target_q  <= target_d;
			done_q    <= done_d;
			dir_up_q  <= dir_up_d;
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			coil_q    <= coil_d;
		end
	end

	// Output register.
	logic [OUT_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			out_data_q <= {2'b00, (target_d != '0), stepped_d, coil_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks on the sequencer.
	`CHK_SAME(a_idle_coils_off, clk, arst_n, target_q == '0, coil_q == '0,
		"coils driven with no step target")
	`CHK_NEXT(a_phase_only_on_step, clk, arst_n, !(upd && stepped_d), $stable(phase_q),
		"phase index moved without a step")
	`CHK_SAME(a_empty_input_ready, clk, arst_n, !v_s1, s_tready,
		"input stalled with an empty input register")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import shmc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;
	localparam int HOLD_AT_WORD = 300;
	// Half-step coil values, phase 0 in the lowest nibble.
	localparam logic [31:0] HALF_STEP_SEQ = 32'h9_8_C_4_6_2_3_1;

	typedef struct packed {
		cmd_t                      cmd;
		logic signed [ANGLE_W-1:0] angle;
	} motor_word_t;

	typedef struct packed {
		logic [COIL_W-1:0] coils;
		logic              stepped;
		logic              busy;
	} motor_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	wire logic            s_tready;
	logic [ANGLE_W-1:0]   s_tdata = '0;
	logic                 s_tuser = 1'b0;
	wire logic            m_tvalid;
	logic                 m_tready = 1'b0;
	wire logic [OUT_W-1:0] m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_STEPS_PER_REV;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	stepper_half_step_move_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Words waiting to be sent and the motor outputs they should produce.
	motor_word_t word_q[$];
	motor_out_t  motor_expect_q[$];

	// Predicted motor state and the register copies it runs with.
	logic [SPR_W-1:0]   cfg_spr = SPR_RESET;
	logic [IVL_W-1:0]   cfg_ivl = IVL_RESET;
	logic [STEP_W-1:0]  tgt_steps = '0;
	logic [STEP_W-1:0]  done_cnt = '0;
	logic               dir_up = 1'b0;
	logic [PHASE_W-1:0] phase_idx = '0;
	logic [IVL_W-1:0]   tick_age = '0;
	logic [COIL_W-1:0]  coil_q = '0;

	int fail_cnt = 0;
	int words_in = 0;
	int results_seen = 0;
	int moves_seen = 0;
	int steps_seen = 0;
	int releases_seen = 0;
	int saturations_seen = 0;
	int settings_seen = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit no_idle = 1'b0;

	// Advance the motor state by one word and return the outputs after it.
	function motor_out_t advance_motor(input motor_word_t w);
		longint     quot;
		longint     mag;
		motor_out_t r;
		r.stepped = 1'b0;
		if (w.cmd == CMD_MOVE) begin
			moves_seen++;
			quot = (longint'(cfg_spr) * longint'(w.angle)) / 360;
			if (quot != 0) begin
				mag = (quot < 0) ? -quot : quot;
				if (mag > longint'(STEP_MAX)) begin
					mag = longint'(STEP_MAX);
					saturations_seen++;
				end
				tgt_steps = STEP_W'(mag);
				dir_up = (quot > 0);
			end
			done_cnt = '0;
		end else begin
			if (tick_age != ELAPSED_MAX)
				tick_age = tick_age + 1'b1;
			if (done_cnt < tgt_steps) begin
				if (tick_age >= cfg_ivl) begin
					coil_q = HALF_STEP_SEQ[4*phase_idx +: 4];
					phase_idx = dir_up ? PHASE_W'(phase_idx + 1) : PHASE_W'(phase_idx - 1);
					done_cnt = done_cnt + 1'b1;
					tick_age = '0;
					r.stepped = 1'b1;
					steps_seen++;
				end
			end else if (tgt_steps != 0 && done_cnt == tgt_steps) begin
				coil_q = '0;
				tgt_steps = '0;
				releases_seen++;
			end
		end
		r.coils = coil_q;
		r.busy = (tgt_steps != 0);
		return r;
	endfunction

	// Sender: offers queued words, idling at random unless a burst is on.
	always @(posedge clk) begin : drive
		logic        offer;
		motor_word_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				motor_expect_q.push_back(advance_motor(motor_word_t'({s_tuser, s_tdata})));
				words_in++;
			end
			if (!s_tvalid || s_tready) begin
				offer = (word_q.size() != 0) && (no_idle || $urandom_range(99) >= 26);
				if (offer) begin
					nxt = word_q.pop_front();
					s_tdata <= nxt.angle;
					s_tuser <= nxt.cmd;
				end
				s_tvalid <= offer;
			end
		end
	end

	// Receiver and checker: one long hold-off, otherwise random stalls.
	always @(posedge clk) begin : watch
		motor_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (motor_expect_q.size() == 0) begin
					$error("result word with nothing expected: %h", m_tdata);
					fail_cnt++;
				end else begin
					want = motor_expect_q.pop_front();
					if (m_tdata[COIL_W-1:0] !== want.coils) begin
						$error("coils: expected %h, got %h", want.coils, m_tdata[COIL_W-1:0]);
						fail_cnt++;
					end
					if (m_tdata[4] !== want.stepped) begin
						$error("stepped: expected %b, got %b", want.stepped, m_tdata[4]);
						fail_cnt++;
					end
					if (m_tdata[5] !== want.busy) begin
						$error("busy_res: expected %b, got %b", want.busy, m_tdata[5]);
						fail_cnt++;
					end
					if (m_tdata[7:6] !== 2'b00) begin
						$error("pad: expected 00, got %b", m_tdata[7:6]);
						fail_cnt++;
					end
				end
			end
			if (!hold_done && results_seen >= HOLD_AT_WORD) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || $urandom_range(99) >= 26;
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic queue_word(input cmd_t cmd, input logic [ANGLE_W-1:0] angle);
		motor_word_t w;
		w.cmd = cmd;
		w.angle = angle;
		word_q.push_back(w);
	endtask

	// Ticks carry a random don't-care angle.
	task automatic queue_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_word(CMD_TICK, ANGLE_W'($urandom));
	endtask

	// Let everything queued go through and every result come back.
	task automatic wait_motor_idle();
		while (word_q.size() != 0 || s_tvalid || motor_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers while the block is idle.
	task automatic apply_settings(input logic [SPR_W-1:0] spr, input logic [IVL_W-1:0] ivl);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_STEPS_PER_REV;
		cfg_wdata <= CFG_W'(spr);
		@(posedge clk);
		cfg_index <= REG_STEP_INTERVAL;
		cfg_wdata <= ivl;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_spr = spr;
		cfg_ivl = ivl;
		settings_seen++;
	endtask

	// Mostly complete moves (a move, then enough ticks to finish and
	// release), mixed with full-range moves, zero-step moves and idle ticks.
	task automatic queue_motion_run(input int n_items);
		int pushed;
		int pick;
		int hi;
		int mag;
		int steps;
		int need;
		logic [ANGLE_W-1:0] ang;
		pushed = 0;
		while (pushed < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				hi = (cfg_spr == 0) ? 100 : 360 * 24 / int'(cfg_spr) + 1;
				mag = $urandom_range(hi, 1);
				ang = $urandom_range(1) ? ANGLE_W'(mag) : ANGLE_W'(-mag);
				steps = int'(cfg_spr) * mag / 360;
				need = steps * (int'(cfg_ivl) + 1) + 2;
				if (need > 150)
					need = 150;
				if ($urandom_range(4) == 0)
					need = $urandom_range(need);
				queue_word(CMD_MOVE, ang);
				queue_ticks(need);
				pushed += need + 1;
			end else if (pick < 85) begin
				need = $urandom_range(6, 1);
				queue_word(CMD_MOVE, ANGLE_W'($urandom));
				queue_ticks(need);
				pushed += need + 1;
			end else if (pick < 92) begin
				need = $urandom_range(8, 1);
				queue_word(CMD_MOVE, '0);
				queue_ticks(need);
				pushed += need + 1;
			end else begin
				need = $urandom_range(10, 1);
				queue_ticks(need);
				pushed += need;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle ticks, a short move that runs out and releases the
		// coils, both angle extremes, and a zero-step move that restarts.
		queue_ticks(2);
		queue_word(CMD_MOVE, ANGLE_W'(1));
		queue_ticks(12);
		queue_word(CMD_MOVE, 16'h8000);
		queue_ticks(3);
		queue_word(CMD_MOVE, '0);
		queue_ticks(2);
		queue_word(CMD_MOVE, 16'h7FFF);
		queue_ticks(2);
		wait_motor_idle();

		// Random runs over several settings; the second one runs without idling.
		apply_settings(SPR_W'(1), IVL_W'(1));
		queue_motion_run(150);
		wait_motor_idle();
		apply_settings(SPR_W'(4096), IVL_W'(0));
		no_idle = 1'b1;
		queue_motion_run(150);
		wait_motor_idle();
		no_idle = 1'b0;
		apply_settings(SPR_W'(8191), IVL_W'(1));
		queue_motion_run(150);
		wait_motor_idle();
		apply_settings(SPR_W'(0), IVL_W'(2));
		queue_motion_run(140);
		wait_motor_idle();
		apply_settings(SPR_W'(360), IVL_W'(3));
		queue_motion_run(150);
		wait_motor_idle();
		apply_settings(SPR_W'(4096), IVL_W'(1));
		queue_motion_run(150);
		wait_motor_idle();

		// A one-degree move at one step per degree, then ticks to finish it
		// and release the coils.
		apply_settings(SPR_W'(360), IVL_W'(1));
		queue_word(CMD_MOVE, ANGLE_W'(1));
		queue_ticks(4);
		wait_motor_idle();

		repeat (8) @(posedge clk);
		if (motor_expect_q.size() != 0) begin
			$error("%0d expected result words never arrived", motor_expect_q.size());
			fail_cnt++;
		end
		$display("Run: %0d words (%0d moves) over %0d register settings.",
			words_in, moves_seen, settings_seen);
		$display("Seen: %0d half steps, %0d coil releases, %0d saturated targets.",
			steps_seen, releases_seen, saturations_seen);
		if (fail_cnt == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
